[design/mrfc_pkg.sv]
// Package for the Modbus request frame checker.
// Holds the shared constants, error codes and the frame summary type.
// No dependencies.
package mrfc_pkg;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'd3;
    localparam logic [7:0]  FUNC_READ_INPUT   = 8'd4;
    localparam logic [3:0]  HEADER_BYTES      = 4'd6;
    localparam logic [3:0]  NEED_RTU          = 4'd8;
    localparam logic [3:0]  NEED_ASCII        = 4'd7;
    localparam logic [3:0]  POS_MAX           = 4'd15;
    localparam logic [3:0]  POS_ADDR          = 4'd0;
    localparam logic [3:0]  POS_FUNC          = 4'd1;
    localparam logic [3:0]  POS_START_LO      = 4'd3;
    localparam logic [3:0]  POS_COUNT_LO      = 4'd5;
    localparam logic [3:0]  POS_CHK0          = 4'd6;
    localparam logic [3:0]  POS_CHK1          = 4'd7;

    localparam logic [7:0] OWN_ADDRESS_RST     = 8'd1;
    localparam logic       ASCII_MODE_RST      = 1'b0;
    localparam logic [7:0] INPUT_REG_TOTAL_RST = 8'd8;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CFG_OWN_ADDRESS     = 2'd0,
        CFG_ASCII_MODE      = 2'd1,
        CFG_INPUT_REG_TOTAL = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_CHECKSUM = 3'd1,
        ERR_ADDRESS  = 3'd2,
        ERR_FUNCTION = 3'd3,
        ERR_START    = 3'd4,
        ERR_SHORT    = 3'd5
    } err_code_t;

    typedef struct packed {
        logic [7:0] own_address;
        logic       ascii_mode;
        logic [7:0] input_reg_total;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  length;
        logic [15:0] crc;
        logic [7:0]  lrc;
        logic [7:0]  address;
        logic [7:0]  func;
        logic [7:0]  start;
        logic [7:0]  count;
        logic [7:0]  chk0;
        logic [7:0]  chk1;
    } frame_sum_t;

endpackage

[design/modbus_request_frame_checker.sv]
// Top level of the Modbus read request frame checker.
// Instantiates mrfc_front, mrfc_queue and mrfc_back; depends on mrfc_pkg.
//
//   Channel   Direction  Handshake            Word
//   s_        in         s_valid / s_ready    one frame byte, last flag
//   m_        out        m_valid / m_ready    one check result per frame
//   cfg_      in         cfg_wr_en            register index and data
//
// One byte is accepted every cycle while s_ready is high; the CRC-16 update
// is a byte-wide unrolled step. A frame's result is registered in the summary
// queue, then in the output register after the check and clamp logic.
// Reset is synchronous and active low; it restores the configuration defaults,
// restarts the frame and empties the queue and the output register.
// s_ready falls only while the summary queue is full of frames whose results wait.
module modbus_request_frame_checker #(
    parameter int QUEUE_DEPTH = mrfc_pkg::QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_frame_byte,
    input  logic       s_frame_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_request_ok,
    output logic [2:0] m_error_code,
    output logic [7:0] m_function_code,
    output logic [7:0] m_start_register,
    output logic [7:0] m_register_count,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    mrfc_pkg::cfg_t       cfg_reg, cfg_next;
    mrfc_pkg::frame_sum_t push_data, head;
    logic                 push, pop, q_full, q_not_empty, in_accept;

    assign s_ready   = !q_full;
    assign in_accept = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (mrfc_pkg::cfg_index_t'(cfg_index))
                mrfc_pkg::CFG_OWN_ADDRESS:     cfg_next.own_address     = cfg_data;
                mrfc_pkg::CFG_ASCII_MODE:      cfg_next.ascii_mode      = cfg_data[0];
                mrfc_pkg::CFG_INPUT_REG_TOTAL: cfg_next.input_reg_total = cfg_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_address     <= mrfc_pkg::OWN_ADDRESS_RST;
            cfg_reg.ascii_mode      <= mrfc_pkg::ASCII_MODE_RST;
            cfg_reg.input_reg_total <= mrfc_pkg::INPUT_REG_TOTAL_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mrfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .frame_byte (s_frame_byte),
        .frame_last (s_frame_last),
        .push       (push),
        .push_data  (push_data)
    );

    mrfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    mrfc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .sum_valid      (q_not_empty),
        .sum            (head),
        .pop            (pop),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .request_ok     (m_request_ok),
        .error_code     (m_error_code),
        .function_code  (m_function_code),
        .start_register (m_start_register),
        .register_count (m_register_count)
    );

    a_ok_matches_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_request_ok == (m_error_code == mrfc_pkg::ERR_NONE)))
        else $error("request_ok disagrees with error_code");

    a_short_clears_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error_code == mrfc_pkg::ERR_SHORT) |->
        (m_function_code == 8'd0 && m_start_register == 8'd0 && m_register_count == 8'd0))
        else $error("short frame result carries request fields");

    a_clamp_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_request_ok && m_function_code == mrfc_pkg::FUNC_READ_INPUT) |->
        (({1'b0, m_start_register} + {1'b0, m_register_count}) <=
         {1'b0, cfg_reg.input_reg_total}))
        else $error("accepted input register read runs past the table");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !push)
        else $error("frame summary pushed into a full queue");

endmodule

[design/mrfc_front.sv]
// Front end of the Modbus request frame checker: takes one byte per word,
// accumulates CRC-16 and LRC, keeps the header fields and pushes a frame summary.
// Depends on mrfc_pkg.
module mrfc_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [7:0]         frame_byte,
    input  logic               frame_last,
    output logic               push,
    output mrfc_pkg::frame_sum_t push_data
);

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mrfc_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    logic [3:0]  pos_reg,  pos_next;
    logic [15:0] crc_reg,  crc_next;
    logic [7:0]  lrc_reg,  lrc_next;
    logic [7:0]  addr_reg, func_reg, start_reg, count_reg, chk0_reg, chk1_reg;
    logic [3:0]  length;

    assign length = (pos_reg == mrfc_pkg::POS_MAX) ? pos_reg : pos_reg + 4'd1;

    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        lrc_next = lrc_reg;
        if (in_accept) begin
            if (frame_last) begin
                pos_next = 4'd0;
                crc_next = mrfc_pkg::CRC_INIT;
                lrc_next = 8'd0;
            end else begin
                pos_next = length;
                if (pos_reg < mrfc_pkg::HEADER_BYTES) begin
                    crc_next = crc_feed(crc_reg, frame_byte);
                    lrc_next = lrc_reg + frame_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 4'd0;
            crc_reg <= mrfc_pkg::CRC_INIT;
            lrc_reg <= 8'd0;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            lrc_reg <= lrc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            if (pos_reg == mrfc_pkg::POS_ADDR)     addr_reg  <= frame_byte;
            if (pos_reg == mrfc_pkg::POS_FUNC)     func_reg  <= frame_byte;
            if (pos_reg == mrfc_pkg::POS_START_LO) start_reg <= frame_byte;
            if (pos_reg == mrfc_pkg::POS_COUNT_LO) count_reg <= frame_byte;
            if (pos_reg == mrfc_pkg::POS_CHK0)     chk0_reg  <= frame_byte;
            if (pos_reg == mrfc_pkg::POS_CHK1)     chk1_reg  <= frame_byte;
        end
    end

    // A frame that ends before the checksum is short, so the accumulators
    // already hold the complete header sum whenever they are checked.
    assign push              = in_accept && frame_last;
    assign push_data.length  = length;
    assign push_data.crc     = crc_reg;
    assign push_data.lrc     = lrc_reg;
    assign push_data.address = addr_reg;
    assign push_data.func    = func_reg;
    assign push_data.start   = start_reg;
    assign push_data.count   = count_reg;
    assign push_data.chk0    = (pos_reg == mrfc_pkg::POS_CHK0) ? frame_byte : chk0_reg;
    assign push_data.chk1    = (pos_reg == mrfc_pkg::POS_CHK1) ? frame_byte : chk1_reg;

endmodule

[design/mrfc_queue.sv]
// Short queue of frame summaries between front and back end.
// Depends on mrfc_pkg.
module mrfc_queue #(
    parameter int DEPTH = mrfc_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  mrfc_pkg::frame_sum_t push_data,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output mrfc_pkg::frame_sum_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    mrfc_pkg::frame_sum_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg,    cnt_next;

    assign full      = (cnt_reg == CNT_FULL);
    assign not_empty = (cnt_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[design/mrfc_back.sv]
// Back end of the Modbus request frame checker: runs the frame checks on a
// summary, clamps the register count and holds the result word.
// Depends on mrfc_pkg.
module mrfc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mrfc_pkg::cfg_t       cfg,
    input  logic                 sum_valid,
    input  mrfc_pkg::frame_sum_t sum,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 request_ok,
    output logic [2:0]           error_code,
    output logic [7:0]           function_code,
    output logic [7:0]           start_register,
    output logic [7:0]           register_count
);

    logic                valid_reg, valid_next;
    mrfc_pkg::err_code_t err_reg,   err_next;
    logic [7:0]          func_reg,  func_next;
    logic [7:0]          start_reg, start_next;
    logic [7:0]          count_reg, count_next;
    logic [3:0]          need;
    logic [7:0]          lrc_final;
    logic [8:0]          span;
    logic                chk_bad;

    assign pop       = sum_valid && (!valid_reg || out_ready);
    assign need      = cfg.ascii_mode ? mrfc_pkg::NEED_ASCII : mrfc_pkg::NEED_RTU;
    assign lrc_final = 8'd0 - sum.lrc;
    assign span      = {1'b0, sum.start} + {1'b0, sum.count};
    assign chk_bad   = cfg.ascii_mode ? (lrc_final != sum.chk0)
                                      : (sum.crc[7:0] != sum.chk0 || sum.crc[15:8] != sum.chk1);

    always_comb begin
        err_next   = mrfc_pkg::ERR_NONE;
        func_next  = sum.func;
        start_next = sum.start;
        count_next = sum.count;
        if (sum.length < need) begin
            err_next   = mrfc_pkg::ERR_SHORT;
            func_next  = 8'd0;
            start_next = 8'd0;
            count_next = 8'd0;
        end else if (chk_bad) begin
            err_next = mrfc_pkg::ERR_CHECKSUM;
        end else if (sum.address != cfg.own_address) begin
            err_next = mrfc_pkg::ERR_ADDRESS;
        end else if (sum.func != mrfc_pkg::FUNC_READ_HOLDING &&
                     sum.func != mrfc_pkg::FUNC_READ_INPUT) begin
            err_next = mrfc_pkg::ERR_FUNCTION;
        end else if (sum.func == mrfc_pkg::FUNC_READ_INPUT &&
                     span > {1'b0, cfg.input_reg_total}) begin
            if (sum.start > cfg.input_reg_total) begin
                err_next = mrfc_pkg::ERR_START;
            end else begin
                count_next = cfg.input_reg_total - sum.start;
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            err_reg   <= err_next;
            func_reg  <= func_next;
            start_reg <= start_next;
            count_reg <= count_next;
        end
    end

    assign out_valid      = valid_reg;
    assign request_ok     = (err_reg == mrfc_pkg::ERR_NONE);
    assign error_code     = err_reg;
    assign function_code  = func_reg;
    assign start_register = start_reg;
    assign register_count = count_reg;

endmodule
